### rtl/fixed_header_frame_receiver_top_macros.svh
// ============================================================================
// Assertion macros for the fixed header frame receiver
// Clocked implication checks that compile out when ASSERT_OFF is set.
// ============================================================================
`ifndef FIXED_HEADER_FRAME_RECEIVER_TOP_MACROS_SVH
`define FIXED_HEADER_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define FHFR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fhfr assertion failed");
// Next-cycle implication.
`define FHFR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fhfr assertion failed");
`else
`define FHFR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FHFR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/fhfr_pkg.sv
// ============================================================================
// fhfr_pkg
// Shared widths, register indexes and reset values of the frame receiver.
// ============================================================================
`default_nettype none

package fhfr_pkg;

    localparam int BYTE_W          = 8;
    localparam int HEADER_BYTES    = 4;
    localparam int HDR_IDX_W       = 2;
    localparam int CFG_IDX_W       = 8;
    localparam int FRAME_BYTES_DEF = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_0  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_1  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NETWORK_ID = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REMOTE_ID = 8'd3;

    // Reset values of the header registers
    localparam logic [BYTE_W-1:0] RST_HEADER_0   = 8'd170;
    localparam logic [BYTE_W-1:0] RST_HEADER_1   = 8'd85;
    localparam logic [BYTE_W-1:0] RST_NETWORK_ID = 8'd1;
    localparam logic [BYTE_W-1:0] RST_REMOTE_ID  = 8'd2;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef byte_t [HEADER_BYTES-1:0] hdr_bank_t;

endpackage

`default_nettype wire

### rtl/fhfr_cell.sv
// ============================================================================
// fhfr_cell
// One byte cell of the frame shift chain.
// ============================================================================
`default_nettype none

module fhfr_cell
(
    input  wire logic           clk,
    input  wire logic           shift,
    input  wire fhfr_pkg::byte_t data_in,
    output fhfr_pkg::byte_t     data_out
);

    fhfr_pkg::byte_t data_reg;
    fhfr_pkg::byte_t data_next;

    // take the neighbor's byte on shift, else hold
    assign data_next = shift ? data_in : data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

`default_nettype wire

### rtl/fhfr_hdr_match.sv
// ============================================================================
// fhfr_hdr_match
// Priority compare of a byte against the four header registers.
// ============================================================================
`default_nettype none

module fhfr_hdr_match
(
    input  wire fhfr_pkg::hdr_bank_t                   hdr,
    input  wire fhfr_pkg::byte_t                       rx_byte,
    input  wire logic [fhfr_pkg::HDR_IDX_W-1:0]        hdr_pos,
    output logic                                       hit
);

    logic [fhfr_pkg::HDR_IDX_W:0] first_idx;

    // first matching register wins; HEADER_BYTES means no match
    always_comb
    begin
        first_idx = (fhfr_pkg::HDR_IDX_W+1)'(fhfr_pkg::HEADER_BYTES);
        for (int k = fhfr_pkg::HEADER_BYTES - 1; k >= 0; k--)
        begin
            if (hdr[k] == rx_byte)
            begin
                first_idx = (fhfr_pkg::HDR_IDX_W+1)'(k);
            end
        end
    end

    assign hit = (first_idx == {1'b0, hdr_pos});

endmodule

`default_nettype wire

### rtl/fixed_header_frame_receiver_top.sv
// ============================================================================
// fixed_header_frame_receiver_top
// Header-synchronized fixed length frame receiver with a shift-chain buffer.
// ============================================================================
// Usage:
//   cfg channel  : cfg_valid/cfg_ready with cfg_index and cfg_data. Indexes
//                  0..3 write header_byte_0, header_byte_1, network_id and
//                  remote_id; other indexes are ignored. cfg_ready is always
//                  high. Write only while the block is idle.
//   in channel   : one rx_byte per beat. The first four positions must match
//                  the header registers in turn; a mismatch drops the
//                  position to 0 and the offending byte is discarded.
//   out channel  : after the last byte of a frame, all FRAME_BYTES bytes are
//                  sent in order, one per beat, frame_last on the final one.
// Timing:
//   The completed frame appears on the out channel the cycle after its last
//   byte and drains at one beat per cycle while out_ready is high, so a frame
//   occupies FRAME_BYTES input beats plus FRAME_BYTES output beats. During
//   the drain in_ready is low: the single shift chain of byte cells serves
//   both filling and readout.
// Stalls: when out_ready is low the chain holds and the current beat stays.
// Reset: position and drain state clear, header registers take their reset
//   values; chain contents are undefined until filled by a frame.
// ============================================================================
`default_nettype none
`include "fixed_header_frame_receiver_top_macros.svh"

module fixed_header_frame_receiver_top
#(
    parameter int FRAME_BYTES = fhfr_pkg::FRAME_BYTES_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [fhfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fhfr_pkg::BYTE_W-1:0]     cfg_data,

    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [fhfr_pkg::BYTE_W-1:0]     rx_byte,

    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [fhfr_pkg::BYTE_W-1:0]          frame_byte,
    output logic                                 frame_last
);

    localparam int POS_W = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_END  = POS_W'(fhfr_pkg::HEADER_BYTES);

    // ------------------------------------------------------------------
    // Header registers
    // ------------------------------------------------------------------
    fhfr_pkg::hdr_bank_t hdr_reg;
    fhfr_pkg::hdr_bank_t hdr_next;
    logic                cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready && (cfg_index <= fhfr_pkg::REG_REMOTE_ID);

    always_comb
    begin
        hdr_next = hdr_reg;
        if (cfg_write)
        begin
            hdr_next[cfg_index[fhfr_pkg::HDR_IDX_W-1:0]] = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg[fhfr_pkg::REG_HEADER_0[fhfr_pkg::HDR_IDX_W-1:0]]   <= fhfr_pkg::RST_HEADER_0;
            hdr_reg[fhfr_pkg::REG_HEADER_1[fhfr_pkg::HDR_IDX_W-1:0]]   <= fhfr_pkg::RST_HEADER_1;
            hdr_reg[fhfr_pkg::REG_NETWORK_ID[fhfr_pkg::HDR_IDX_W-1:0]] <=
                fhfr_pkg::RST_NETWORK_ID;
            hdr_reg[fhfr_pkg::REG_REMOTE_ID[fhfr_pkg::HDR_IDX_W-1:0]]  <= fhfr_pkg::RST_REMOTE_ID;
        end
        else
        begin
            hdr_reg <= hdr_next;
        end
    end

    // ------------------------------------------------------------------
    // Position tracking and header match
    // ------------------------------------------------------------------
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] emit_cnt_reg;
    logic [POS_W-1:0] emit_cnt_next;
    logic             emit_reg;
    logic             emit_next;
    logic             in_fire;
    logic             out_fire;
    logic             in_header;
    logic             hdr_hit;
    logic             store;
    logic             shift;

    fhfr_hdr_match u_hdr_match
    (
        .hdr     (hdr_reg),
        .rx_byte (rx_byte),
        .hdr_pos (pos_reg[fhfr_pkg::HDR_IDX_W-1:0]),
        .hit     (hdr_hit)
    );

    assign in_ready  = !emit_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign in_header = (pos_reg < HDR_END);
    assign store     = in_fire && (!in_header || hdr_hit);
    // fill and drain never overlap, so one shift serves both
    assign shift     = store || out_fire;

    always_comb
    begin
        pos_next      = pos_reg;
        emit_next     = emit_reg;
        emit_cnt_next = emit_cnt_reg;
        if (in_fire)
        begin
            if (!store)
            begin
                // drop back to frame start; this byte is not retried
                pos_next = '0;
            end
            else if (pos_reg == LAST_POS)
            begin
                pos_next      = '0;
                emit_next     = 1'b1;
                emit_cnt_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        if (out_fire)
        begin
            emit_cnt_next = emit_cnt_reg + 1'b1;
            if (emit_cnt_reg == LAST_POS)
            begin
                emit_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            emit_reg     <= 1'b0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            emit_reg     <= emit_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Shift chain: new bytes enter at the tail, the head feeds the output
    // ------------------------------------------------------------------
    fhfr_pkg::byte_t chain_q [FRAME_BYTES];

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_BYTES; gi++)
        begin : g_cell
            if (gi == FRAME_BYTES - 1)
            begin : g_tail
                fhfr_cell u_cell
                (
                    .clk      (clk),
                    .shift    (shift),
                    .data_in  (rx_byte),
                    .data_out (chain_q[gi])
                );
            end
            else
            begin : g_body
                fhfr_cell u_cell
                (
                    .clk      (clk),
                    .shift    (shift),
                    .data_in  (chain_q[gi+1]),
                    .data_out (chain_q[gi])
                );
            end
        end
    endgenerate

    assign out_valid  = emit_reg;
    assign frame_byte = chain_q[0];
    assign frame_last = (emit_cnt_reg == LAST_POS);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `FHFR_ASSERT_IMP(a_no_fill_in_drain, clk, rst_n, out_valid, !in_ready)
    `FHFR_ASSERT_NXT(a_drain_ends, clk, rst_n, out_fire && frame_last, !out_valid)
    `FHFR_ASSERT_NXT(a_frame_starts, clk, rst_n, store && (pos_reg == LAST_POS),
        out_valid && (emit_cnt_reg == '0) && (pos_reg == '0))
    `FHFR_ASSERT_IMP(a_idle_pos_zero, clk, rst_n, out_valid, pos_reg == '0)

endmodule

`default_nettype wire
